>>> sv/wtsc_pkg.sv
// ----------------------------------------------------------------------------
// wtsc_pkg: shared definitions for the wave table sound channel
// Field widths, operation codes, register indexes and memory geometry.
// ----------------------------------------------------------------------------
package wtsc_pkg;

  // Wave memory geometry
  localparam int unsigned BANK_BYTES = 16;
  localparam int unsigned NUM_BANKS  = 2;
  localparam int unsigned MEM_DEPTH  = NUM_BANKS * BANK_BYTES;
  localparam int unsigned BYTE_AW    = $clog2(BANK_BYTES);
  localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);
  localparam int unsigned POS_W      = $clog2(2 * BANK_BYTES);

  // Payload field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 4;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_BANK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_3Q    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_EN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LENGTH = 3'd6;

  // Countdown widths and reload bases
  localparam int unsigned TONE_W = 12;
  localparam int unsigned LEN_W  = 9;
  localparam logic [TONE_W-1:0] TONE_BASE = 12'h800;
  localparam logic [LEN_W-1:0]  LEN_BASE  = 9'd256;

  // Operations carried by one input transfer
  typedef enum logic [OP_W-1:0] {
    OP_FREQ_TICK   = 3'd0,
    OP_LENGTH_TICK = 3'd1,
    OP_TRIGGER     = 3'd2,
    OP_WAVE_WRITE  = 3'd3,
    OP_WAVE_READ   = 3'd4,
    OP_SAMPLE      = 3'd5,
    OP_SET_BANK    = 3'd6
  } wtsc_op_e;

  // Volume codes
  localparam logic [1:0] VOL_MUTE    = 2'd0;
  localparam logic [1:0] VOL_FULL    = 2'd1;
  localparam logic [1:0] VOL_HALF    = 2'd2;
  localparam logic [1:0] VOL_QUARTER = 2'd3;

endpackage

>>> sv/wtsc_in_if.sv
// ----------------------------------------------------------------------------
// wtsc_in_if: input channel of the wave table sound channel
// Valid/ready handshake carrying one operation per transfer.
// ----------------------------------------------------------------------------
interface wtsc_in_if;

  logic                              valid;
  logic                              ready;
  logic [wtsc_pkg::OP_W-1:0]         op;
  logic [wtsc_pkg::BYTE_AW-1:0]      wave_index;
  logic [wtsc_pkg::BYTE_W-1:0]       wave_byte;
  logic                              bank;

  modport source (output valid, output op, output wave_index, output wave_byte,
                  output bank, input ready);
  modport sink   (input valid, input op, input wave_index, input wave_byte,
                  input bank, output ready);

endinterface

>>> sv/wtsc_out_if.sv
// ----------------------------------------------------------------------------
// wtsc_out_if: result channel of the wave table sound channel
// Valid/ready handshake carrying one result per transfer.
// ----------------------------------------------------------------------------
interface wtsc_out_if;

  logic                              valid;
  logic                              ready;
  logic [wtsc_pkg::SAMPLE_W-1:0]     sample_out;
  logic [wtsc_pkg::BYTE_W-1:0]       read_data;
  logic                              channel_active;

  modport source (output valid, output sample_out, output read_data,
                  output channel_active, input ready);
  modport sink   (input valid, input sample_out, input read_data,
                  input channel_active, output ready);

endinterface

>>> sv/wave_table_sound_channel_core.sv
// ----------------------------------------------------------------------------
// wave_table_sound_channel_core: wave table sound channel
// Two banks of 4-bit samples, tone and length countdowns, volume scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per transfer: frequency tick, length tick,
//   trigger, wave write, wave read, sample query or bank select. Every
//   transfer on in_i yields exactly one transfer on out_o with the scaled
//   sample, the wave byte read (zero unless a read) and the active flag.
//   Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_wdata_i
//   while the channel is idle, which only the user ensures; indexes past the list are ignored.
// Timing:
//   An operation transfers in, updates channel state and reads the wave
//   memory into the read stage register s1 at that edge; s1 then moves into
//   the output register once that is empty or being taken. Throughput is one
//   transfer per cycle while out_o takes every result.
// Reset:
//   rst_ni clears all channel state, the configuration and the 32 per-byte
//   valid bits of the wave memory, so every byte reads as zero until written.
// Stall:
//   When out_o is not taken, the output register holds, one more operation
//   is taken into the read stage, and then in_i.ready drops until out_o
//   moves again.
// ----------------------------------------------------------------------------
module wave_table_sound_channel_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  wtsc_in_if.sink                                in_i,
  wtsc_out_if.source                             out_o,
  input  logic                                   cfg_we_i,
  input  logic [wtsc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [wtsc_pkg::CFG_DATA_W-1:0]        cfg_wdata_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [10:0] period_q;
  logic        two_bank_q;
  logic        play_en_q;
  logic [1:0]  volume_q;
  logic        force_3q_q;
  logic        length_en_q;
  logic [7:0]  init_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= '0;
      two_bank_q    <= 1'b0;
      play_en_q     <= 1'b0;
      volume_q      <= '0;
      force_3q_q    <= 1'b0;
      length_en_q   <= 1'b0;
      init_length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wtsc_pkg::CFG_PERIOD:      period_q      <= cfg_wdata_i[10:0];
        wtsc_pkg::CFG_TWO_BANK:    two_bank_q    <= cfg_wdata_i[0];
        wtsc_pkg::CFG_PLAY_EN:     play_en_q     <= cfg_wdata_i[0];
        wtsc_pkg::CFG_VOLUME:      volume_q      <= cfg_wdata_i[1:0];
        wtsc_pkg::CFG_FORCE_3Q:    force_3q_q    <= cfg_wdata_i[0];
        wtsc_pkg::CFG_LENGTH_EN:   length_en_q   <= cfg_wdata_i[0];
        wtsc_pkg::CFG_INIT_LENGTH: init_length_q <= cfg_wdata_i[7:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: read stage (s1) and output register
  // --------------------------------------------------------------------------
  logic s1_vld_q, s1_vld_d;
  logic out_vld_q, out_vld_d;
  logic s1_adv;
  logic in_fire;

  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (in_fire) begin
      s1_vld_d = 1'b1;
    end else if (s1_adv) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_adv) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // --------------------------------------------------------------------------
  // Channel state
  // --------------------------------------------------------------------------
  logic [wtsc_pkg::POS_W-1:0]  pos_q, pos_d;
  logic                        play_bank_q, play_bank_d;
  logic                        sel_bank_q, sel_bank_d;
  logic [wtsc_pkg::TONE_W-1:0] tone_q, tone_d;
  logic [wtsc_pkg::LEN_W-1:0]  len_q, len_d;
  logic                        running_q, running_d;
  logic                        expired_q, expired_d;

  logic [wtsc_pkg::TONE_W-1:0] tone_reload;
  logic [wtsc_pkg::LEN_W-1:0]  len_reload;
  logic                        playing;

  assign tone_reload = wtsc_pkg::TONE_BASE - {1'b0, period_q};
  assign len_reload  = wtsc_pkg::LEN_BASE - {1'b0, init_length_q};
  assign playing     = running_q && !expired_q;

  always_comb begin
    pos_d       = pos_q;
    play_bank_d = play_bank_q;
    sel_bank_d  = sel_bank_q;
    tone_d      = tone_q;
    len_d       = len_q;
    running_d   = running_q;
    expired_d   = expired_q;
    if (in_fire) begin
      case (in_i.op)
        wtsc_pkg::OP_FREQ_TICK: begin
          if (playing) begin
            if (tone_q > wtsc_pkg::TONE_W'(1)) begin
              tone_d = tone_q - wtsc_pkg::TONE_W'(1);
            end else begin
              // Reload and step one nibble; in two-bank mode the last nibble wraps the bank.
              tone_d = tone_reload;
              pos_d  = pos_q + wtsc_pkg::POS_W'(1);
              if (&pos_q && two_bank_q) begin
                play_bank_d = !play_bank_q;
              end
            end
          end
        end
        wtsc_pkg::OP_LENGTH_TICK: begin
          if (playing && length_en_q) begin
            if (len_q > wtsc_pkg::LEN_W'(1)) begin
              len_d = len_q - wtsc_pkg::LEN_W'(1);
            end else begin
              len_d     = '0;
              expired_d = 1'b1;
            end
          end
        end
        wtsc_pkg::OP_TRIGGER: begin
          expired_d   = 1'b0;
          running_d   = 1'b1;
          pos_d       = '0;
          play_bank_d = sel_bank_q;
          tone_d      = tone_reload;
          len_d       = len_reload;
        end
        wtsc_pkg::OP_SET_BANK: begin
          // A real change of bank also moves playback to it.
          if (in_i.bank != sel_bank_q) begin
            sel_bank_d  = in_i.bank;
            play_bank_d = in_i.bank;
          end
        end
        default: ; // writes, reads, sample queries and the unused code
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      play_bank_q <= 1'b0;
      sel_bank_q  <= 1'b0;
      tone_q      <= '0;
      len_q       <= '0;
      running_q   <= 1'b0;
      expired_q   <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      play_bank_q <= play_bank_d;
      sel_bank_q  <= sel_bank_d;
      tone_q      <= tone_d;
      len_q       <= len_d;
      running_q   <= running_d;
      expired_q   <= expired_d;
    end
  end

  // --------------------------------------------------------------------------
  // Wave memory: one write port, two registered read ports, per-byte valid
  // bits so unwritten bytes read as zero after reset.
  // --------------------------------------------------------------------------
  logic [wtsc_pkg::BYTE_W-1:0]    wave_mem_q [wtsc_pkg::MEM_DEPTH];
  logic [wtsc_pkg::MEM_DEPTH-1:0] wave_vld_q;

  logic                        wr_en;
  logic                        rd_en;
  logic [wtsc_pkg::MEM_AW-1:0] cpu_addr;
  logic [wtsc_pkg::MEM_AW-1:0] smp_addr;
  logic                        smp_bypass;

  // CPU side always targets the bank that is not selected.
  assign cpu_addr   = {!sel_bank_q, in_i.wave_index};
  assign smp_addr   = {play_bank_d, pos_d[wtsc_pkg::POS_W-1:1]};
  assign wr_en      = in_fire && (in_i.op == wtsc_pkg::OP_WAVE_WRITE);
  assign rd_en      = in_fire && (in_i.op == wtsc_pkg::OP_WAVE_READ);
  // The sample of a write transfer must see the byte it just wrote.
  assign smp_bypass = wr_en && (cpu_addr == smp_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wave_mem_q[cpu_addr] <= in_i.wave_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_vld_q <= '0;
    end else if (wr_en) begin
      wave_vld_q[cpu_addr] <= 1'b1;
    end
  end

  // Read stage payload
  logic [wtsc_pkg::BYTE_W-1:0] s1_sbyte_q;
  logic                        s1_lo_q;
  logic [wtsc_pkg::BYTE_W-1:0] s1_rdata_q;
  logic                        s1_expired_q;
  logic                        s1_active_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (smp_bypass) begin
        s1_sbyte_q <= in_i.wave_byte;
      end else if (wave_vld_q[smp_addr]) begin
        s1_sbyte_q <= wave_mem_q[smp_addr];
      end else begin
        s1_sbyte_q <= '0;
      end
      if (rd_en && wave_vld_q[cpu_addr]) begin
        s1_rdata_q <= wave_mem_q[cpu_addr];
      end else begin
        s1_rdata_q <= '0;
      end
      s1_lo_q      <= pos_d[0];
      s1_expired_q <= expired_d;
      s1_active_q  <= running_d && !expired_d;
    end
  end

  // --------------------------------------------------------------------------
  // Volume scaling and output register
  // --------------------------------------------------------------------------
  logic [wtsc_pkg::SAMPLE_W-1:0]   nib;
  logic [wtsc_pkg::SAMPLE_W+1:0]   nib_x3;
  logic [wtsc_pkg::SAMPLE_W-1:0]   scaled;

  assign nib    = s1_lo_q ? s1_sbyte_q[3:0] : s1_sbyte_q[7:4];
  assign nib_x3 = {2'b00, nib} + {1'b0, nib, 1'b0};

  always_comb begin
    scaled = '0;
    if (!s1_expired_q && play_en_q) begin
      if (force_3q_q) begin
        scaled = nib_x3[wtsc_pkg::SAMPLE_W+1:2];
      end else begin
        case (volume_q)
          wtsc_pkg::VOL_MUTE:    scaled = '0;
          wtsc_pkg::VOL_FULL:    scaled = nib;
          wtsc_pkg::VOL_HALF:    scaled = nib >> 1;
          wtsc_pkg::VOL_QUARTER: scaled = nib >> 2;
          default:               scaled = '0;
        endcase
      end
    end
  end

  logic [wtsc_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [wtsc_pkg::BYTE_W-1:0]   out_rdata_q;
  logic                          out_active_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_sample_q <= scaled;
      out_rdata_q  <= s1_rdata_q;
      out_active_q <= s1_active_q;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.sample_out     = out_sample_q;
  assign out_o.read_data      = out_rdata_q;
  assign out_o.channel_active = out_active_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTHESIS
  // Input stalls only when both stages are full and the output is held.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled while a stage is free");

  // Expiry is only reachable from a running channel.
  a_expired_implies_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    expired_q |-> running_q)
    else $error("channel expired without running");

  // The tone countdown never exceeds its reload base.
  a_tone_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_q <= wtsc_pkg::TONE_BASE)
    else $error("tone countdown out of range");

  // A frequency tick at the end of the countdown advances one nibble.
  a_nibble_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.op == wtsc_pkg::OP_FREQ_TICK) && playing &&
     (tone_q <= wtsc_pkg::TONE_W'(1)))
    |=> (pos_q == wtsc_pkg::POS_W'($past(pos_q) + wtsc_pkg::POS_W'(1))))
    else $error("nibble position did not advance");
`endif

endmodule
